// File: hdl/gbi_pkg.sv
// ----------------------------------------------------------------------------
// gbi_pkg
// Shared sizes, codes and helpers for the 2x grid boundary interpolator.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int MAX_J       = 32;
  localparam int MAX_K       = 32;
  localparam int MAX_VARS    = 8;
  localparam int NLAYERS     = 3;
  localparam int STORE_DEPTH = MAX_J * MAX_K * NLAYERS * MAX_VARS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int JW          = $clog2(MAX_J);
  localparam int KW          = $clog2(MAX_K);
  localparam int VW          = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int ROW_W       = $clog2(MAX_VARS * NLAYERS + 1);

  localparam int DATA_W      = 32;
  localparam int COEF_W      = 5;
  localparam int ACC_W       = 40;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_VALID = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_J = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_K = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_J   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_K   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CSIZE_J = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CSIZE_K = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FSIZE_J = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FSIZE_K = 4'd7;

  // controls for the shared multiply-accumulate unit
  typedef struct packed {
    logic              clr;
    logic              add_inner;
    logic              add_outer;
    logic [COEF_W-1:0] coef;
  } mac_ctrl_t;

  // blend weight of one read: tap weight 9/3/3/1, middle layer scaled by 3
  function automatic logic [COEF_W-1:0] tap_coef(input logic [3:0] step);
    logic [COEF_W-1:0] w;
    begin
      case (step[1:0])
        2'd0:    w = 5'd9;
        2'd1:    w = 5'd3;
        2'd2:    w = 5'd3;
        default: w = 5'd1;
      endcase
      if (step[3:2] == 2'd1) begin
        tap_coef = w * 5'd3;
      end else begin
        tap_coef = w;
      end
    end
  endfunction

  // store address from zero-based j, k, layer and variable
  function automatic logic [ADDR_W-1:0] store_addr(input logic [JW-1:0] j0,
                                                   input logic [KW-1:0] k0,
                                                   input logic [1:0]    lyr0,
                                                   input logic [VW-1:0] var0);
    logic [ROW_W-1:0] row;
    begin
      row = ROW_W'(var0) * ROW_W'(NLAYERS) + ROW_W'(lyr0);
      store_addr = ADDR_W'(row) * ADDR_W'(MAX_J * MAX_K)
                 + ADDR_W'(k0) * ADDR_W'(MAX_J) + ADDR_W'(j0);
    end
  endfunction

endpackage

// File: hdl/gbi_mac.sv
// ----------------------------------------------------------------------------
// gbi_mac
// Shared multiply-accumulate unit with round-to-nearest output stage.
// ----------------------------------------------------------------------------
module gbi_mac (
  input  logic                                clk,
  input  gbi_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [gbi_pkg::DATA_W-1:0]   data,
  output logic signed [gbi_pkg::DATA_W-1:0]   round_inner,
  output logic signed [gbi_pkg::DATA_W-1:0]   round_outer
);
  import gbi_pkg::*;

  localparam int PROD_W = DATA_W + COEF_W + 1;
  localparam int RES_W  = ACC_W - 6;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_inner;
  logic signed [ACC_W-1:0]  acc_outer;

  assign prod     = data * $signed({1'b0, ctrl.coef});
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_inner <= '0;
      acc_outer <= '0;
    end else begin
      if (ctrl.add_inner) begin
        acc_inner <= acc_inner + prod_ext;
      end
      if (ctrl.add_outer) begin
        acc_outer <= acc_outer + prod_ext;
      end
    end
  end

  // acc is 64x the result: add half, shift, saturate
  function automatic logic signed [DATA_W-1:0] rnd(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [RES_W-1:0] r;
    begin
      s = a + ACC_W'(32);
      r = RES_W'(s >>> 6);
      if (r > RES_W'(64'sd2147483647)) begin
        rnd = 32'sh7fffffff;
      end else if (r < -RES_W'(64'sd2147483648)) begin
        rnd = 32'sh80000000;
      end else begin
        rnd = r[DATA_W-1:0];
      end
    end
  endfunction

  assign round_inner = rnd(acc_inner);
  assign round_outer = rnd(acc_outer);

endmodule

// File: hdl/grid_boundary_2x_interpolator.sv
// ----------------------------------------------------------------------------
// grid_boundary_2x_interpolator
// Handshake: a load gives its done strobe in the cycle after the accepting edge
// and the next word can be taken at once. A query steps through CHECK, READ and
// FIN, or CHECK alone when out of range, and is busy until done; the twelve
// coarse reads through the single port of the coarse store set the READ length.
// Reset restores the register defaults; the coarse store is not cleared.
// ----------------------------------------------------------------------------
module grid_boundary_2x_interpolator (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cmd,
  input  logic [6:0]                             pos_j,
  input  logic [6:0]                             pos_k,
  input  logic [1:0]                             layer,
  input  logic [3:0]                             variable,
  input  logic signed [gbi_pkg::DATA_W-1:0]      value_in,
  output logic                                   done,
  output logic signed [gbi_pkg::DATA_W-1:0]      value_inner,
  output logic signed [gbi_pkg::DATA_W-1:0]      value_outer,
  output logic [1:0]                             status,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gbi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import gbi_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_READ  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;
  localparam logic [3:0] LAST_STEP = 4'd12;

  logic [1:0] state;
  logic [1:0] state_next;

  // configuration
  logic [5:0] start_j, start_k, end_j, end_k, csize_j, csize_k;
  logic [6:0] fsize_j, fsize_k;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_j <= 6'd1;
      start_k <= 6'd1;
      end_j   <= 6'd33;
      end_k   <= 6'd33;
      csize_j <= 6'd33;
      csize_k <= 6'd33;
      fsize_j <= 7'd65;
      fsize_k <= 7'd65;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_J: start_j <= cfg_data[5:0];
        REG_START_K: start_k <= cfg_data[5:0];
        REG_END_J:   end_j   <= cfg_data[5:0];
        REG_END_K:   end_k   <= cfg_data[5:0];
        REG_CSIZE_J: csize_j <= cfg_data[5:0];
        REG_CSIZE_K: csize_k <= cfg_data[5:0];
        REG_FSIZE_J: fsize_j <= cfg_data[6:0];
        REG_FSIZE_K: fsize_k <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // accept and load path
  logic accept;
  logic load_ok;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] addr;
  logic signed [DATA_W-1:0] rdata;
  logic signed [DATA_W-1:0] store [STORE_DEPTH];

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign load_ok = (pos_j >= 7'd1) && (pos_j <= 7'(MAX_J))
                && (pos_k >= 7'd1) && (pos_k <= 7'(MAX_K))
                && (layer >= 2'd1) && (layer <= 2'(NLAYERS))
                && (variable >= 4'd1) && (variable <= 4'(MAX_VARS));
  assign we    = accept && (cmd == CMD_LOAD) && load_ok;
  assign waddr = store_addr(JW'(pos_j - 7'd1), KW'(pos_k - 7'd1), layer - 2'd1,
                            VW'(variable - 4'd1));
  assign addr  = we ? waddr : raddr;

  always_ff @(posedge clk) begin
    if (we) begin
      store[addr] <= value_in;
    end
    rdata <= store[addr];
  end

  // query word
  logic [6:0] q_j, q_k;
  logic [3:0] q_var;

  always_ff @(posedge clk) begin
    if (accept) begin
      q_j   <= pos_j;
      q_k   <= pos_k;
      q_var <= variable;
    end
  end

  // parent and neighbor cells, range check
  logic signed [9:0] pj, pk, lim_j, lim_k;
  logic signed [9:0] cj, ck, nj, nk;
  logic q_ok;

  always_comb begin
    pj = $signed({3'b0, q_j}) - ((q_j == fsize_j) ? 10'sd1 : 10'sd0);
    pk = $signed({3'b0, q_k}) - ((q_k == fsize_k) ? 10'sd1 : 10'sd0);
    lim_j = ($signed({4'b0, end_j}) - $signed({4'b0, start_j})) <<< 1;
    lim_k = ($signed({4'b0, end_k}) - $signed({4'b0, start_k})) <<< 1;
    cj = $signed({4'b0, start_j}) + ((pj - 10'sd1) >>> 1);
    ck = $signed({4'b0, start_k}) + ((pk - 10'sd1) >>> 1);
    nj = cj - 10'sd1 + (((pj - 10'sd1) & 10'sd1) <<< 1);
    nk = ck - 10'sd1 + (((pk - 10'sd1) & 10'sd1) <<< 1);
    if (nj < 10'sd1) begin
      nj = 10'sd1;
    end
    if (nj > $signed({4'b0, csize_j}) - 10'sd1) begin
      nj = $signed({4'b0, csize_j}) - 10'sd1;
    end
    if (nk < 10'sd1) begin
      nk = 10'sd1;
    end
    if (nk > $signed({4'b0, csize_k}) - 10'sd1) begin
      nk = $signed({4'b0, csize_k}) - 10'sd1;
    end
    q_ok = (pj >= 10'sd1) && (pj <= lim_j) && (pk >= 10'sd1) && (pk <= lim_k)
        && (q_var >= 4'd1) && (q_var <= 4'(MAX_VARS))
        && (cj >= 10'sd1) && (cj <= 10'(MAX_J)) && (nj >= 10'sd1) && (nj <= 10'(MAX_J))
        && (ck >= 10'sd1) && (ck <= 10'(MAX_K)) && (nk >= 10'sd1) && (nk <= 10'(MAX_K));
  end

  // read sequencer
  logic [JW-1:0] j0, j2;
  logic [KW-1:0] k0, k2;
  logic [VW-1:0] v0;
  logic [3:0] step;
  logic [3:0] step_d;
  logic       rd_vld;

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      j0 <= JW'(cj - 10'sd1);
      j2 <= JW'(nj - 10'sd1);
      k0 <= KW'(ck - 10'sd1);
      k2 <= KW'(nk - 10'sd1);
      v0 <= VW'(q_var - 4'd1);
    end
    step_d <= step;
  end

  assign raddr = store_addr(step[1] ? j2 : j0, step[0] ? k2 : k0, step[3:2], v0);

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_READ) && (step != LAST_STEP);
      if (state == S_READ) begin
        step <= step + 4'd1;
      end else begin
        step <= '0;
      end
    end
  end

  // shared multiply-accumulate
  mac_ctrl_t mac_ctrl;
  logic signed [DATA_W-1:0] round_inner, round_outer;

  always_comb begin
    mac_ctrl.clr       = (state == S_CHECK);
    mac_ctrl.coef      = tap_coef(step_d);
    mac_ctrl.add_inner = rd_vld && (step_d[3:2] != 2'd2);
    mac_ctrl.add_outer = rd_vld && (step_d[3:2] != 2'd0);
  end

  gbi_mac u_mac (
    .clk         (clk),
    .ctrl        (mac_ctrl),
    .data        (rdata),
    .round_inner (round_inner),
    .round_outer (round_outer)
  );

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept && (cmd == CMD_QUERY)) state_next = S_CHECK;
      S_CHECK: state_next = q_ok ? S_READ : S_IDLE;
      S_READ:  if (step == LAST_STEP) state_next = S_FIN;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (accept && (cmd == CMD_LOAD)) || ((state == S_CHECK) && !q_ok)
            || (state == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      value_inner <= round_inner;
      value_outer <= round_outer;
      status      <= ST_VALID;
    end else if (state == S_CHECK) begin
      value_inner <= '0;
      value_outer <= '0;
      status      <= ST_RANGE;
    end else begin
      value_inner <= '0;
      value_outer <= '0;
      status      <= ST_LOAD;
    end
  end

  // checks
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd == CMD_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> done && (status == ST_VALID))
    else $error("finished query gave no valid word");

  a_load_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_LOAD) |-> (value_inner == 0) && (value_outer == 0))
    else $error("load word carries nonzero values");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_RANGE) |-> (value_inner == 0) && (value_outer == 0))
    else $error("out of range word carries nonzero values");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !we)
    else $error("store written during a query");

endmodule

// File: dv/grid_boundary_2x_interpolator_tb.sv
// ----------------------------------------------------------------------------
// grid_boundary_2x_interpolator_tb
// Self-checking bench for the 2x grid boundary interpolator. Coarse values are
// loaded and fine points are queried through the start/busy port, with random
// gaps and bursts. The register set is reprogrammed between phases, the
// extremes among them. A checker class keeps its own coarse store and
// registers and predicts the blended pair and status of every word. Each
// done strobe is compared with the oldest prediction. A query only touches
// coarse entries that were loaded first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module grid_boundary_2x_interpolator_tb;
  import gbi_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd12;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{REG_START_J, REG_START_K, REG_END_J,
                                                      REG_END_K, REG_CSIZE_J, REG_CSIZE_K,
                                                      REG_FSIZE_J, REG_FSIZE_K};

  typedef struct packed {
    logic [DATA_W-1:0] inner;
    logic [DATA_W-1:0] outer;
    logic [1:0]        st;
  } outcome_t;

  class upsample_checker;
    int       start_j, start_k, end_j, end_k;
    int       coarse_j_size, coarse_k_size, fine_j_size, fine_k_size;
    bit       loaded [STORE_DEPTH];
    int       coarse [STORE_DEPTH];
    outcome_t pending_results [$];
    int       mismatch_count;

    function new();
      start_j = 1;
      start_k = 1;
      end_j = 33;
      end_k = 33;
      coarse_j_size = 33;
      coarse_k_size = 33;
      fine_j_size = 65;
      fine_k_size = 65;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_START_J: start_j = int'(data[5:0]);
        REG_START_K: start_k = int'(data[5:0]);
        REG_END_J:   end_j = int'(data[5:0]);
        REG_END_K:   end_k = int'(data[5:0]);
        REG_CSIZE_J: coarse_j_size = int'(data[5:0]);
        REG_CSIZE_K: coarse_k_size = int'(data[5:0]);
        REG_FSIZE_J: fine_j_size = int'(data[6:0]);
        REG_FSIZE_K: fine_k_size = int'(data[6:0]);
        default: ;
      endcase
    endfunction

    function int cell_addr(int j, int k, int lyr, int v);
      return (((v - 1) * NLAYERS + (lyr - 1)) * MAX_K + (k - 1)) * MAX_J + (j - 1);
    endfunction

    function bit in_store(int j, int k, int lyr, int v);
      return j >= 1 && j <= MAX_J && k >= 1 && k <= MAX_K && lyr >= 1 && lyr <= NLAYERS &&
             v >= 1 && v <= MAX_VARS;
    endfunction

    function bit is_loaded(int j, int k, int lyr, int v);
      return loaded[cell_addr(j, k, lyr, v)];
    endfunction

    function int neighbor(int c, int sel, int csize);
      int n;
      n = c - 1 + 2 * sel;
      if (n < 1) n = 1;
      if (n > csize - 1) n = csize - 1;
      return n;
    endfunction

    // parent cell and neighbors of a fine point, 0 when flagged
    function bit locate(input int pj, input int pk, input int v,
                        output int j, output int k, output int j2, output int k2);
      j = 0;
      k = 0;
      j2 = 0;
      k2 = 0;
      if (pj == fine_j_size) pj = pj - 1;
      if (pk == fine_k_size) pk = pk - 1;
      if (pj < 1 || pj > 2 * (end_j - start_j)) return 0;
      if (pk < 1 || pk > 2 * (end_k - start_k)) return 0;
      if (v < 1 || v > MAX_VARS) return 0;
      j = start_j + (pj - 1) / 2;
      k = start_k + (pk - 1) / 2;
      j2 = neighbor(j, (pj - 1) % 2, coarse_j_size);
      k2 = neighbor(k, (pk - 1) % 2, coarse_k_size);
      if (j < 1 || j > MAX_J || j2 < 1 || j2 > MAX_J) return 0;
      if (k < 1 || k > MAX_K || k2 < 1 || k2 > MAX_K) return 0;
      return 1;
    endfunction

    function longint coarse_at(int j, int k, int lyr, int v);
      return longint'(coarse[cell_addr(j, k, lyr, v)]);
    endfunction

    // sixteen times the blended layer value
    function longint blend_layer(int j, int k, int j2, int k2, int lyr, int v);
      return 9 * coarse_at(j, k, lyr, v)
           + 3 * (coarse_at(j, k2, lyr, v) + coarse_at(j2, k, lyr, v))
           + coarse_at(j2, k2, lyr, v);
    endfunction

    // x holds 64 times the value; nearest, ties up, saturated
    function logic [DATA_W-1:0] round_q16(longint x);
      longint r;
      r = (x + 32) >>> 6;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[DATA_W-1:0];
    endfunction

    function void note_word(logic c, int pj, int pk, int lyr, int v, logic [DATA_W-1:0] val);
      outcome_t e;
      int       j, k, j2, k2;
      longint   s [NLAYERS];
      e.inner = '0;
      e.outer = '0;
      e.st = ST_LOAD;
      if (c == CMD_LOAD) begin
        if (in_store(pj, pk, lyr, v)) begin
          coarse[cell_addr(pj, pk, lyr, v)] = int'(val);
          loaded[cell_addr(pj, pk, lyr, v)] = 1'b1;
        end
      end else begin
        e.st = ST_RANGE;
        if (locate(pj, pk, v, j, k, j2, k2)) begin
          for (int l = 0; l < NLAYERS; l++) s[l] = blend_layer(j, k, j2, k2, l + 1, v);
          e.inner = round_q16(s[0] + 3 * s[1]);
          e.outer = round_q16(3 * s[1] + s[2]);
          e.st = ST_VALID;
        end
      end
      pending_results.push_back(e);
    endfunction

    function void compare_result(logic [DATA_W-1:0] inner, logic [DATA_W-1:0] outer,
                                 logic [1:0] st);
      outcome_t e;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected word: inner %h outer %h status %0d", $time, inner,
                   outer, st);
        return;
      end
      e = pending_results.pop_front();
      if (e.inner !== inner || e.outer !== outer || e.st !== st) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: mismatch: expected %h %h status %0d, got %h %h status %0d",
                   $time, e.inner, e.outer, e.st, inner, outer, st);
      end
    endfunction

    function void flush_leftovers();
      outcome_t e;
      while (pending_results.size() != 0) begin
        e = pending_results.pop_front();
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("missing word: expected inner %h outer %h status %0d", e.inner, e.outer,
                   e.st);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     cmd = CMD_LOAD;
  logic [6:0]               pos_j = '0;
  logic [6:0]               pos_k = '0;
  logic [1:0]               layer = '0;
  logic [3:0]               variable = '0;
  logic signed [DATA_W-1:0] value_in = '0;
  logic                     done;
  logic signed [DATA_W-1:0] value_inner;
  logic signed [DATA_W-1:0] value_outer;
  logic [1:0]               status;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  upsample_checker checker_h;
  bit              burst = 1'b0;
  int              words_sent = 0;

  grid_boundary_2x_interpolator i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("grid_boundary_2x_interpolator_tb: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && done) checker_h.compare_result(value_inner, value_outer, status);
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 16);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return DATA_W'($signed($urandom_range(0, 511)) - 256);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input int gap, input logic c, input int pj, input int pk,
                           input int lyr, input int v, input logic [DATA_W-1:0] val);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    pos_j <= pj[6:0];
    pos_k <= pk[6:0];
    layer <= lyr[1:0];
    variable <= v[3:0];
    value_in <= val;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    checker_h.note_word(c, pj, pk, lyr, v, val);
    words_sent++;
  endtask

  // loads any coarse entry the point still lacks, then queries it
  task automatic query_point(input int pj, input int pk, input int v);
    int j, k, j2, k2, jj, kk;
    if (checker_h.locate(pj, pk, v, j, k, j2, k2)) begin
      for (int l = 1; l <= NLAYERS; l++) begin
        for (int t = 0; t < 4; t++) begin
          jj = t[0] ? j2 : j;
          kk = t[1] ? k2 : k;
          if (!checker_h.is_loaded(jj, kk, l, v))
            send_word(pick_gap(), CMD_LOAD, jj, kk, l, v, rand_value());
        end
      end
    end
    send_word(pick_gap(), CMD_QUERY, pj, pk, $urandom_range(1, 3), v, $urandom());
  endtask

  task automatic drain(input int tail);
    start <= 1'b0;
    while (checker_h.pending_results.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic configure(input int vals [8], input bit spare);
    logic [CFG_DATA_W-1:0] data;
    drain(4);
    for (int i = 0; i < (spare ? 9 : 8); i++) begin
      if ($urandom_range(0, 3) == 0) begin
        cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      data = (i == 8) ? CFG_DATA_W'($urandom()) : CFG_DATA_W'(vals[i]);
      // high bits beyond the register width are dropped
      if (i < 8 && $urandom_range(0, 1) == 1) begin
        if (i < 6) data[7:6] = 2'($urandom_range(0, 3));
        else data[7] = 1'($urandom_range(0, 1));
      end
      cfg_index <= (i == 8) ? REG_SPARE : REG_ORDER[i];
      cfg_data <= data;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      checker_h.set_reg((i == 8) ? REG_SPARE : REG_ORDER[i], data);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_axis(input int span, input int fsize, output int p);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75 && span > 0) p = $urandom_range(1, (span < 65) ? span : 65);
    else if (r < 87) p = fsize;
    else p = $urandom_range(1, 65);
  endtask

  task automatic run_phase(input int count);
    int target, pj, pk, v;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(0, 39) == 0) burst = !burst;
      if ($urandom_range(0, 99) < 72) begin
        pick_axis(2 * (checker_h.end_j - checker_h.start_j), checker_h.fine_j_size, pj);
        pick_axis(2 * (checker_h.end_k - checker_h.start_k), checker_h.fine_k_size, pk);
        v = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 2) : $urandom_range(1, MAX_VARS);
        query_point(pj, pk, v);
      end else begin
        pj = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65) : $urandom_range(1, MAX_J);
        pk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65) : $urandom_range(1, MAX_K);
        send_word(pick_gap(), CMD_LOAD, pj, pk, $urandom_range(1, 3),
                  $urandom_range(1, MAX_VARS), rand_value());
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] trio [5][3];
    int                tvar [5];
    int                sj, ej, sk, ek;
    trio = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff},
             '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
             '{32'hffff_ffff, 32'h0000_0001, 32'hffff_fffe},
             '{32'hffff_fffd, 32'hffff_ffff, 32'h0000_0001},
             '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}};
    tvar = '{1, MAX_VARS, 3, 4, 1};
    checker_h = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners at full scale, rounding ties both signs, far corner with both clamps
    for (int n = 0; n < 5; n++) begin
      for (int l = 0; l < NLAYERS; l++)
        send_word(pick_gap(), CMD_LOAD, (n == 4) ? MAX_J : 1, (n == 4) ? MAX_K : 1, l + 1,
                  tvar[n], trio[n][l]);
      query_point((n == 4) ? 65 : 1, (n == 4) ? 65 : 1, tvar[n]);
    end
    // load outside the store is dropped
    send_word(pick_gap(), CMD_LOAD, 65, 33, 2, 5, 32'h1234_5678);
    query_point(64, 1, 1);

    run_phase(150);
    configure('{32, 32, 33, 33, 33, 33, 2, 2}, 1'b0);
    run_phase(90);
    configure('{1, 1, 2, 2, 2, 2, 2, 2}, 1'b0);
    run_phase(70);
    configure('{5, 3, 20, 9, 21, 10, 31, 13}, 1'b1);
    run_phase(140);
    // start past end in j: every query flagged
    configure('{20, 3, 2, 33, 17, 33, 65, 40}, 1'b0);
    run_phase(50);
    configure('{1, 1, 33, 33, 33, 33, 65, 65}, 1'b1);
    run_phase(100);
    for (int n = 0; n < 2; n++) begin
      sj = $urandom_range(1, 32);
      sk = $urandom_range(1, 32);
      ej = sj + $urandom_range(1, 8);
      ek = sk + $urandom_range(1, 8);
      if (ej > 33) ej = 33;
      if (ek > 33) ek = 33;
      configure('{sj, sk, ej, ek, $urandom_range(2, 33), $urandom_range(2, 33),
                  $urandom_range(2, 65), $urandom_range(2, 65)}, 1'b0);
      run_phase(125);
    end

    drain(24);
    checker_h.flush_leftovers();
    if (checker_h.mismatch_count == 0) begin
      $display("grid_boundary_2x_interpolator_tb: clean");
    end else begin
      $display("grid_boundary_2x_interpolator_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/gbi_pkg.sv
hdl/gbi_mac.sv
hdl/grid_boundary_2x_interpolator.sv
dv/grid_boundary_2x_interpolator_tb.sv
